[sv/thct_pkg.sv]
`default_nettype none

package thct_pkg;

  // Field widths fixed by the item format
  localparam int TAG_W      = 10;
  localparam int HIT_W      = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_ADDR_W = 3;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 32;

  // Output tdata bit positions
  localparam int OUT_TAG_LSB   = 0;
  localparam int OUT_CNT_LSB   = 10;
  localparam int OUT_VALID_BIT = 26;
  localparam int OUT_REM_BIT   = 27;
  localparam int OUT_DROP_BIT  = 28;

  // Input kind carried on tuser
  localparam logic ACT_DETECT = 1'b0;
  localparam logic ACT_FRAME  = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_BASE_COUNT     = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_INCREMENT_STEP = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_DECREMENT_STEP = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_REMOVE_LEVEL   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_COUNT      = 3'd4;

  // Count unit operations
  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_LOAD
  } alu_op_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_FREAD,
    ST_FEVAL
  } state_t;

endpackage

`default_nettype wire

[sv/thct_table.sv]
`default_nettype none

// Tag and count store: one write port, one registered read port
module thct_table #(
  parameter int SLOTS   = 16,
  parameter int COUNT_W = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 we,
  input  wire logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] waddr,
  input  wire logic [thct_pkg::TAG_W-1:0]           wtag,
  input  wire logic [COUNT_W-1:0]                   wcnt,
  input  wire logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] raddr,
  output logic      [thct_pkg::TAG_W-1:0]           rtag,
  output logic      [COUNT_W-1:0]                   rcnt
);

  localparam int ENTRY_W = thct_pkg::TAG_W + COUNT_W;

  logic [ENTRY_W-1:0] mem [SLOTS];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {wtag, wcnt};
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    {rtag, rcnt} <= mem[raddr];
  end

endmodule

`default_nettype wire

[sv/thct_alu.sv]
`default_nettype none

// Shared count unit: add with ceiling, subtract floored at zero, or load.
// Every result is clamped to the count width.
module thct_alu #(
  parameter int COUNT_W = 16
) (
  input  wire thct_pkg::alu_op_t                op,
  input  wire logic [COUNT_W-1:0]               a,
  input  wire logic [thct_pkg::CFG_DATA_W-1:0]  b,
  input  wire logic [thct_pkg::CFG_DATA_W-1:0]  lim,
  output logic      [COUNT_W-1:0]               res,
  output logic                                  at_or_below
);

  localparam int EW = ((COUNT_W > thct_pkg::CFG_DATA_W) ? COUNT_W : thct_pkg::CFG_DATA_W) + 1;

  logic [EW-1:0] ae, be, lm, cmax, sum, diff, pick, clamped;

  always_comb begin
    ae   = EW'(a);
    be   = EW'(b);
    lm   = EW'(lim);
    cmax = EW'({COUNT_W{1'b1}});
    sum  = ae + be;
    diff = (ae > be) ? (ae - be) : '0;
    case (op)
      thct_pkg::ALU_ADD:  pick = (sum < lm) ? sum : lm;
      thct_pkg::ALU_SUB:  pick = diff;
      thct_pkg::ALU_LOAD: pick = be;
      default:            pick = be;
    endcase
    clamped     = (pick > cmax) ? cmax : pick;
    res         = COUNT_W'(clamped);
    at_or_below = (diff <= lm);
  end

endmodule

`default_nettype wire

[sv/tag_hit_count_tracker_top.sv]
`default_nettype none

// Channel  Dir  tdata                         tuser       tlast
// in       in   [9:0] tag_id, rest zero       [0] action  -
// out      out  [9:0] out_tag_id, [25:10]     -           last
//               hit_count, [26] entry_valid,
//               [27] removed, [28] dropped
// cfg      in   plain write: cfg_we, cfg_addr, cfg_wdata
//
// Detection: the lookup reads the tag/count store one slot per cycle through
// its single read port, then ST_WRITE updates the entry and loads the result.
// End of frame: each slot is read (ST_FREAD), then evaluated and written back
// (ST_FEVAL) while its result is loaded. in_tready is high only while no
// request is in progress; a stalled output holds its result and the sequencer
// waits. rst is synchronous; valid and seen bits clear at once, no clearing
// pass is needed.
module tag_hit_count_tracker_top #(
  parameter int TABLE_SLOTS = 16,
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [thct_pkg::IN_DATA_W-1:0]      in_tdata,   // [9:0] tag_id
  input  wire logic [0:0]                          in_tuser,   // [0] action
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // [9:0] out_tag_id, [25:10] hit_count, [26] entry_valid, [27] removed, [28] dropped
  output logic      [thct_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                                     out_tlast,
  input  wire logic                                cfg_we,
  input  wire logic [thct_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  wire logic [thct_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CW = $clog2(TABLE_SLOTS + 1);
  localparam int TW = thct_pkg::TAG_W;
  localparam int DW = thct_pkg::CFG_DATA_W;
  localparam int HW = thct_pkg::HIT_W;

  // Configuration registers
  logic [DW-1:0] base_count, increment_step, decrement_step, remove_level, max_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_count     <= DW'(1);
      increment_step <= DW'(1);
      decrement_step <= DW'(1);
      remove_level   <= DW'(0);
      max_count      <= DW'(5);
    end else if (cfg_we) begin
      case (cfg_addr)
        thct_pkg::REG_BASE_COUNT:     base_count     <= cfg_wdata;
        thct_pkg::REG_INCREMENT_STEP: increment_step <= cfg_wdata;
        thct_pkg::REG_DECREMENT_STEP: decrement_step <= cfg_wdata;
        thct_pkg::REG_REMOVE_LEVEL:   remove_level   <= cfg_wdata;
        thct_pkg::REG_MAX_COUNT:      max_count      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Sequencer and working registers
  thct_pkg::state_t state, state_next;

  logic [TW-1:0]          tag_q;
  logic [CW-1:0]          scan_cnt, scan_cnt_next;
  logic                   hit_found, free_found;
  logic [IW-1:0]          hit_idx, free_idx;
  logic [COUNT_WIDTH-1:0] hit_cnt;
  logic [TABLE_SLOTS-1:0] valid_bits, seen_bits;

  // Store and count unit hookup
  logic                   mem_we;
  logic [IW-1:0]          mem_waddr, mem_raddr;
  logic [TW-1:0]          mem_wtag, rd_tag;
  logic [COUNT_WIDTH-1:0] mem_wcnt, rd_cnt;

  thct_pkg::alu_op_t      alu_op;
  logic [COUNT_WIDTH-1:0] alu_a, alu_res;
  logic [DW-1:0]          alu_b, alu_lim;
  logic                   alu_le;

  thct_table #(.SLOTS(TABLE_SLOTS), .COUNT_W(COUNT_WIDTH)) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wtag  (mem_wtag),
    .wcnt  (mem_wcnt),
    .raddr (mem_raddr),
    .rtag  (rd_tag),
    .rcnt  (rd_cnt)
  );

  thct_alu #(.COUNT_W(COUNT_WIDTH)) u_alu (
    .op          (alu_op),
    .a           (alu_a),
    .b           (alu_b),
    .lim         (alu_lim),
    .res         (alu_res),
    .at_or_below (alu_le)
  );

  // Output register fields
  logic [TW-1:0] o_tag;
  logic [HW-1:0] o_cnt;
  logic          o_valid, o_rem, o_drop, o_last;

  // Per-cycle decisions
  logic          in_acc, out_free, out_load;
  logic [TW-1:0] ld_tag;
  logic [HW-1:0] ld_cnt;
  logic          ld_valid, ld_rem, ld_drop, ld_last;
  logic [IW-1:0] scan_e, fr_idx, bit_idx;
  logic          scan_eval, scan_hit, scan_free;
  logic          vb_set, vb_clr, sn_set, sn_clr;

  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !out_tvalid || out_tready;
  assign scan_e   = IW'(scan_cnt - CW'(1));
  assign fr_idx   = IW'(scan_cnt);

  // Next state, store and unit controls
  always_comb begin
    state_next    = state;
    scan_cnt_next = scan_cnt;
    in_tready     = (state == thct_pkg::ST_IDLE);
    mem_we        = 1'b0;
    mem_waddr     = fr_idx;
    mem_wtag      = rd_tag;
    mem_wcnt      = alu_res;
    mem_raddr     = '0;
    alu_op        = thct_pkg::ALU_SUB;
    alu_a         = rd_cnt;
    alu_b         = decrement_step;
    alu_lim       = remove_level;
    out_load      = 1'b0;
    ld_tag        = tag_q;
    ld_cnt        = '0;
    ld_valid      = 1'b0;
    ld_rem        = 1'b0;
    ld_drop       = 1'b0;
    ld_last       = 1'b1;
    scan_eval     = 1'b0;
    scan_hit      = 1'b0;
    scan_free     = 1'b0;
    vb_set        = 1'b0;
    vb_clr        = 1'b0;
    sn_set        = 1'b0;
    sn_clr        = 1'b0;
    bit_idx       = fr_idx;

    case (state)
      thct_pkg::ST_IDLE: begin
        scan_cnt_next = '0;
        if (in_acc) begin
          state_next = (in_tuser[0] == thct_pkg::ACT_FRAME) ? thct_pkg::ST_FREAD
                                                            : thct_pkg::ST_SCAN;
        end
      end

      // lookup: read slot scan_cnt, judge slot scan_cnt-1
      thct_pkg::ST_SCAN: begin
        if (scan_cnt < CW'(TABLE_SLOTS)) begin
          mem_raddr = IW'(scan_cnt);
        end
        scan_eval = (scan_cnt != '0);
        scan_hit  = scan_eval && valid_bits[scan_e] && !hit_found && (rd_tag == tag_q);
        scan_free = scan_eval && !valid_bits[scan_e] && !free_found;
        if (scan_cnt == CW'(TABLE_SLOTS)) begin
          state_next = thct_pkg::ST_WRITE;
        end else begin
          scan_cnt_next = scan_cnt + CW'(1);
        end
      end

      // detection update and result
      thct_pkg::ST_WRITE: begin
        alu_op  = hit_found ? thct_pkg::ALU_ADD : thct_pkg::ALU_LOAD;
        alu_a   = hit_cnt;
        alu_b   = hit_found ? increment_step : base_count;
        alu_lim = max_count;
        mem_waddr = hit_found ? hit_idx : free_idx;
        mem_wtag  = tag_q;
        bit_idx   = hit_found ? hit_idx : free_idx;
        if (out_free) begin
          out_load = 1'b1;
          ld_tag   = tag_q;
          if (hit_found || free_found) begin
            mem_we   = 1'b1;
            vb_set   = 1'b1;
            sn_set   = 1'b1;
            ld_cnt   = HW'(alu_res);
            ld_valid = 1'b1;
          end else begin
            ld_drop  = 1'b1;
          end
          state_next = thct_pkg::ST_IDLE;
        end
      end

      thct_pkg::ST_FREAD: begin
        mem_raddr  = fr_idx;
        state_next = thct_pkg::ST_FEVAL;
      end

      // frame pass: age or keep one slot and report it
      thct_pkg::ST_FEVAL: begin
        mem_raddr = fr_idx;
        if (out_free) begin
          out_load = 1'b1;
          sn_clr   = 1'b1;
          ld_last  = (scan_cnt == CW'(TABLE_SLOTS - 1));
          if (!valid_bits[fr_idx]) begin
            ld_tag = '0;
          end else if (seen_bits[fr_idx]) begin
            ld_tag   = rd_tag;
            ld_cnt   = HW'(rd_cnt);
            ld_valid = 1'b1;
          end else begin
            mem_we   = 1'b1;
            ld_tag   = rd_tag;
            ld_cnt   = HW'(alu_res);
            ld_valid = !alu_le;
            ld_rem   = alu_le;
            vb_clr   = alu_le;
          end
          if (ld_last) begin
            state_next = thct_pkg::ST_IDLE;
          end else begin
            scan_cnt_next = scan_cnt + CW'(1);
            state_next    = thct_pkg::ST_FREAD;
          end
        end
      end

      default: begin
        state_next = thct_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= thct_pkg::ST_IDLE;
      scan_cnt   <= '0;
      valid_bits <= '0;
      seen_bits  <= '0;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
      out_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      scan_cnt <= scan_cnt_next;
      if (in_acc) begin
        hit_found  <= 1'b0;
        free_found <= 1'b0;
      end else begin
        if (scan_hit)  hit_found  <= 1'b1;
        if (scan_free) free_found <= 1'b1;
      end
      if (vb_set) valid_bits[bit_idx] <= 1'b1;
      if (vb_clr) valid_bits[bit_idx] <= 1'b0;
      if (sn_set) seen_bits[bit_idx]  <= 1'b1;
      if (sn_clr) seen_bits[bit_idx]  <= 1'b0;
      if (out_load) begin
        out_tvalid <= 1'b1;
      end else if (out_tready) begin
        out_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      tag_q <= in_tdata[TW-1:0];
    end
    if (scan_hit) begin
      hit_idx <= scan_e;
      hit_cnt <= rd_cnt;
    end
    if (scan_free) begin
      free_idx <= scan_e;
    end
    if (out_load) begin
      o_tag   <= ld_tag;
      o_cnt   <= ld_cnt;
      o_valid <= ld_valid;
      o_rem   <= ld_rem;
      o_drop  <= ld_drop;
      o_last  <= ld_last;
    end
  end

  assign out_tdata = {3'b000, o_drop, o_rem, o_valid, o_cnt, o_tag};
  assign out_tlast = o_last;

endmodule

`default_nettype wire

[sv/thct_checker.sv]
`default_nettype none

// Port-level checks on the tracker
module thct_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            in_tvalid,
  input wire logic                            in_tready,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [thct_pkg::OUT_DATA_W-1:0] out_tdata,
  input wire logic                            out_tlast
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output changed while stalled");

  // one request at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while busy");

  // a dropped detection is a single, invalid, final result
  a_drop: assert property (@(posedge clk) disable iff (rst)
    out_tvalid && out_tdata[thct_pkg::OUT_DROP_BIT] |->
      !out_tdata[thct_pkg::OUT_VALID_BIT] && !out_tdata[thct_pkg::OUT_REM_BIT] && out_tlast)
    else $error("dropped result malformed");

  // a freed entry is no longer valid
  a_rem: assert property (@(posedge clk) disable iff (rst)
    out_tvalid && out_tdata[thct_pkg::OUT_REM_BIT] |->
      !out_tdata[thct_pkg::OUT_VALID_BIT] && !out_tdata[thct_pkg::OUT_DROP_BIT])
    else $error("removed entry reported valid");

  // empty slot reports zero id and count
  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_tvalid && !out_tdata[thct_pkg::OUT_VALID_BIT] && !out_tdata[thct_pkg::OUT_REM_BIT]
      && !out_tdata[thct_pkg::OUT_DROP_BIT] |-> out_tdata[25:0] == 26'd0)
    else $error("empty slot has nonzero payload");

endmodule

bind tag_hit_count_tracker_top thct_checker u_thct_checker (.*);

`default_nettype wire
